@@ rtl/mhp_pkg.sv @@
// ----------------------------------------------------------------------------
// mhp_pkg
// Types, constants and helpers shared by the MAC header parser modules.
// ----------------------------------------------------------------------------
package mhp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned FCW_W     = 16;
	localparam int unsigned PAN_W     = 16;
	localparam int unsigned ADDR_W    = 64;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned HDR_LEN_W = 5;

	// addressing mode codes
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_SHORT = 2'd2;
	localparam logic [1:0] MODE_LONG  = 2'd3;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_SHORT = 1'b1;

	// last byte index of a field
	localparam logic [IDX_W-1:0] IDX_LAST_SHORT = 3'd1;
	localparam logic [IDX_W-1:0] IDX_LAST_LONG  = 3'd7;

	typedef enum logic [2:0] {
		PH_FC0   = 3'd0,
		PH_FC1   = 3'd1,
		PH_SEQ   = 3'd2,
		PH_DPAN  = 3'd3,
		PH_DADDR = 3'd4,
		PH_SPAN  = 3'd5,
		PH_SADDR = 3'd6,
		PH_SKIP  = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [IDX_W-1:0]       idx;
		logic [HDR_LEN_W-1:0]   seen;
		logic [FCW_W-1:0]       cw;
		logic [BYTE_W-1:0]      seq;
		logic [PAN_W-1:0]       dpan;
		logic [ADDR_W-1:0]      daddr;
		logic [PAN_W-1:0]       span;
		logic [ADDR_W-1:0]      saddr;
	} hdr_state_t;

	typedef struct packed {
		logic                   status;
		logic [1:0]             frame_kind;
		logic [3:0]             flag_bits;
		logic [1:0]             dst_mode;
		logic [1:0]             src_mode;
		logic [1:0]             frame_version;
		logic [BYTE_W-1:0]      seq_number;
		logic [PAN_W-1:0]       dest_pan;
		logic [ADDR_W-1:0]      dest_addr;
		logic [PAN_W-1:0]       src_pan;
		logic [ADDR_W-1:0]      src_addr;
		logic [HDR_LEN_W-1:0]   header_length;
	} hdr_result_t;

	localparam hdr_state_t STATE_RESET = '{
		phase: PH_FC0, idx: '0, seen: '0, cw: '0, seq: '0,
		dpan: '0, daddr: '0, span: '0, saddr: '0
	};

	function automatic logic [1:0] dst_mode_of(logic [FCW_W-1:0] cw);
		return cw[11:10];
	endfunction

	function automatic logic [1:0] src_mode_of(logic [FCW_W-1:0] cw);
		return cw[15:14];
	endfunction

	function automatic logic pan_comp_of(logic [FCW_W-1:0] cw);
		return cw[6];
	endfunction

	// modes short and long both have the high bit set
	function automatic phase_t next_phase(phase_t after, logic [FCW_W-1:0] cw);
		logic   has_dst;
		logic   has_src;
		logic   has_span;
		phase_t p;
		has_dst  = cw[11];
		has_src  = cw[15];
		has_span = cw[15] & ~cw[6];
		p        = PH_SKIP;
		case (after)
			PH_FC0, PH_FC1, PH_SEQ: begin
				if (has_dst)
					p = PH_DPAN;
				else if (has_span)
					p = PH_SPAN;
				else if (has_src)
					p = PH_SADDR;
			end
			PH_DPAN: begin
				if (has_dst)
					p = PH_DADDR;
				else if (has_span)
					p = PH_SPAN;
				else if (has_src)
					p = PH_SADDR;
			end
			PH_DADDR: begin
				if (has_span)
					p = PH_SPAN;
				else if (has_src)
					p = PH_SADDR;
			end
			PH_SPAN: begin
				if (has_src)
					p = PH_SADDR;
			end
			default: p = PH_SKIP;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/mhp_decode.sv @@
// ----------------------------------------------------------------------------
// mhp_decode
// Per-byte header walk: folds one frame byte into the parse state and forms
// the result beat when the header completes or the frame ends early.
// ----------------------------------------------------------------------------
module mhp_decode import mhp_pkg::*; (
	input  hdr_state_t              state,
	input  logic [BYTE_W-1:0]       frame_byte,
	input  logic                    is_last,
	output hdr_state_t              state_next,
	output logic                    emit,
	output hdr_result_t             result
);

	hdr_state_t       upd;
	logic             field_end;
	logic [IDX_W-1:0] idx_last;

	// datapath: place the byte and step the phase
	always_comb begin
		upd       = state;
		field_end = 1'b0;
		idx_last  = IDX_LAST_SHORT;
		if (state.phase != PH_SKIP)
			upd.seen = state.seen + HDR_LEN_W'(1);
		unique case (state.phase)
			PH_FC0: begin
				upd.cw    = {{(FCW_W-BYTE_W){1'b0}}, frame_byte};
				upd.phase = PH_FC1;
			end
			PH_FC1: begin
				upd.cw[FCW_W-1:BYTE_W] = frame_byte;
				upd.phase              = PH_SEQ;
			end
			PH_SEQ: begin
				upd.seq   = frame_byte;
				upd.phase = next_phase(PH_SEQ, state.cw);
			end
			PH_DPAN: begin
				upd.dpan[{state.idx[0], 3'b000} +: BYTE_W] = frame_byte;
				field_end = 1'b1;
			end
			PH_DADDR: begin
				upd.daddr[{state.idx, 3'b000} +: BYTE_W] = frame_byte;
				if (dst_mode_of(state.cw) == MODE_LONG)
					idx_last = IDX_LAST_LONG;
				field_end = 1'b1;
			end
			PH_SPAN: begin
				upd.span[{state.idx[0], 3'b000} +: BYTE_W] = frame_byte;
				field_end = 1'b1;
			end
			PH_SADDR: begin
				upd.saddr[{state.idx, 3'b000} +: BYTE_W] = frame_byte;
				if (src_mode_of(state.cw) == MODE_LONG)
					idx_last = IDX_LAST_LONG;
				field_end = 1'b1;
			end
			PH_SKIP: begin
				upd.phase = PH_SKIP;
			end
			default: upd.phase = PH_SKIP;
		endcase
		if (field_end) begin
			if (state.idx == idx_last) begin
				upd.idx   = '0;
				upd.phase = next_phase(state.phase, state.cw);
			end else begin
				upd.idx = state.idx + IDX_W'(1);
			end
		end
	end

	// next state: a last byte always restarts the frame
	always_comb begin
		if (is_last)
			state_next = STATE_RESET;
		else
			state_next = upd;
	end

	// result beat
	always_comb begin
		emit   = 1'b0;
		result = '0;
		if (state.phase != PH_SKIP) begin
			if (upd.phase == PH_SKIP) begin
				emit                 = 1'b1;
				result.status        = STATUS_OK;
				result.frame_kind    = upd.cw[1:0];
				result.flag_bits     = upd.cw[6:3];
				result.dst_mode      = dst_mode_of(upd.cw);
				result.src_mode      = src_mode_of(upd.cw);
				result.frame_version = upd.cw[13:12];
				result.seq_number    = upd.seq;
				result.dest_pan      = upd.dpan;
				result.dest_addr     = upd.daddr;
				result.src_pan       = upd.span;
				result.src_addr      = upd.saddr;
				result.header_length = upd.seen;
				// compressed source PAN comes from the destination
				if (upd.cw[15] && pan_comp_of(upd.cw))
					result.src_pan = upd.dpan;
			end else if (is_last) begin
				emit          = 1'b1;
				result.status = STATUS_SHORT;
			end
		end
	end

endmodule

@@ rtl/mhp_out_reg.sv @@
// ----------------------------------------------------------------------------
// mhp_out_reg
// Result register: holds one header beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mhp_out_reg import mhp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  hdr_result_t result,
	input  logic        out_ready,
	output logic        out_valid,
	output hdr_result_t result_q,
	output logic        free
);

	logic valid_q;

	assign free      = ~valid_q | out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= result;
	end

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.status == STATUS_SHORT |->
			result_q.header_length == '0 && result_q.dest_addr == '0
			&& result_q.src_addr == '0 && result_q.seq_number == '0)
		else $error("error beat carries nonzero fields");
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.status == STATUS_OK |->
			result_q.header_length >= HDR_LEN_W'(3)
			&& result_q.header_length <= HDR_LEN_W'(23))
		else $error("header length out of range");
	a_comp_pan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_q.status == STATUS_OK && result_q.src_mode[1]
			&& result_q.flag_bits[3] |-> result_q.src_pan == result_q.dest_pan)
		else $error("compressed source PAN differs from destination PAN");
`endif

endmodule

@@ rtl/ieee802154_mac_header_parser.sv @@
// The result beat is registered and appears in the cycle after the byte that
// completes the header (or the early last byte) is accepted.
// Throughput: one frame byte per cycle; the result register frees in the
// same cycle its beat is taken, so the input stalls only while it is held.
// Reset: arst_n clears the parse state and drops any pending result beat.
// ----------------------------------------------------------------------------
// ieee802154_mac_header_parser
// Byte-stream IEEE 802.15.4 MAC header parser with one result per frame.
// ----------------------------------------------------------------------------
module ieee802154_mac_header_parser import mhp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     frame_byte,
	input  logic                  is_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status,
	output logic [1:0]            frame_kind,
	output logic [3:0]            flag_bits,
	output logic [1:0]            dst_mode,
	output logic [1:0]            src_mode,
	output logic [1:0]            frame_version,
	output logic [BYTE_W-1:0]     seq_number,
	output logic [PAN_W-1:0]      dest_pan,
	output logic [ADDR_W-1:0]     dest_addr,
	output logic [PAN_W-1:0]      src_pan,
	output logic [ADDR_W-1:0]     src_addr,
	output logic [HDR_LEN_W-1:0]  header_length
);

	hdr_state_t  state_q;
	hdr_state_t  state_next;
	hdr_result_t result;
	hdr_result_t result_q;
	logic        emit;
	logic        free;
	logic        accept;

	assign in_ready = free;
	assign accept   = in_valid & free;

	mhp_decode u_decode (
		.state      (state_q),
		.frame_byte (frame_byte),
		.is_last    (is_last),
		.state_next (state_next),
		.emit       (emit),
		.result     (result)
	);

	// advance the parse state on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	mhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept & emit),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result_q  (result_q),
		.free      (free)
	);

	assign status        = result_q.status;
	assign frame_kind    = result_q.frame_kind;
	assign flag_bits     = result_q.flag_bits;
	assign dst_mode      = result_q.dst_mode;
	assign src_mode      = result_q.src_mode;
	assign frame_version = result_q.frame_version;
	assign seq_number    = result_q.seq_number;
	assign dest_pan      = result_q.dest_pan;
	assign dest_addr     = result_q.dest_addr;
	assign src_pan       = result_q.src_pan;
	assign src_addr      = result_q.src_addr;
	assign header_length = result_q.header_length;

`ifndef ASSERT_OFF
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_last |=> state_q.phase == PH_FC0 && state_q.seen == '0
			&& state_q.cw == '0)
		else $error("frame state not cleared after last beat");
	a_skip_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_SKIP |-> state_q.idx == '0)
		else $error("field index left nonzero after header");
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q.phase == PH_SKIP |=> $stable(result_q) || !out_valid)
		else $error("trailing beat produced a result");
`endif

endmodule
